// ===== rtl/core/friction_cone_projection_macros.svh =====
// Assertion macros shared by the friction cone projection RTL.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef FRICTION_CONE_PROJECTION_MACROS_SVH
`define FRICTION_CONE_PROJECTION_MACROS_SVH
`ifndef SYNTHESIS
`define FCP_ASSERT_IMP(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`define FCP_ASSERT_NXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define FCP_ASSERT_IMP(lbl, a, b, msg)
`define FCP_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

// ===== rtl/core/fcp_pkg.sv =====
// Package for the friction cone projection: payload types, case codes,
// pipeline context and chain depths. Depends on nothing.
package fcp_pkg;

	localparam logic [2:0] CODE_NONE         = 3'd0;
	localparam logic [2:0] CODE_FRICTIONLESS = 3'd1;
	localparam logic [2:0] CODE_ZERO         = 3'd2;
	localparam logic [2:0] CODE_INSIDE       = 3'd3;
	localparam logic [2:0] CODE_PROJ         = 3'd4;

	localparam int SQ_STEPS  = 32;
	localparam int DIV1_BITS = 38;
	localparam int DEN_W     = 33;
	localparam int DIV2_BITS = 30;
	localparam int RATIO_W   = 44;

	typedef struct packed {
		logic signed [31:0] normal_force;
		logic signed [31:0] tangent_u;
		logic signed [31:0] tangent_v;
		logic [15:0]        friction_coef;
		logic signed [31:0] cohesion_force;
		logic               tangents_present;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_normal;
		logic signed [31:0] new_u;
		logic signed [31:0] new_v;
		logic [2:0]         case_code;
	} result_t;

	typedef struct packed {
		logic signed [31:0] nf;
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic signed [31:0] coh;
		logic signed [32:0] fn;
		logic [15:0]        m;
		logic               tp;
		logic [2:0]         code;
		logic [DEN_W-1:0]   den;
		logic [31:0]        ft;
		logic               neg;
		logic [DIV1_BITS-1:0] pm;
		logic [RATIO_W-1:0] b;
		logic               r_zero;
		logic               r_full;
	} ctx_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		logic signed [31:0] r;
		if (x > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/fcp_sqrt_cell.sv =====
// One digit step of the integer square root chain, with context carried along.
// Depends on fcp_pkg.
module fcp_sqrt_cell import fcp_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_in,
	input  logic [63:0] x_in,
	input  logic [63:0] res_in,
	input  ctx_t        ctx_in,
	output logic        valid_out,
	output logic [63:0] x_out,
	output logic [63:0] res_out,
	output ctx_t        ctx_out
);
	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	logic        ge;
	logic        valid_q;
	logic [63:0] x_q, res_q;
	ctx_t        ctx_q;

	assign trial = res_in + BIT;
	assign ge    = x_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= ge ? x_in - trial : x_in;
			res_q <= ge ? (res_in >> 1) + BIT : res_in >> 1;
			ctx_q <= ctx_in;
		end
	end

	assign valid_out = valid_q;
	assign x_out     = x_q;
	assign res_out   = res_q;
	assign ctx_out   = ctx_q;
endmodule

// ===== rtl/core/fcp_div_cell.sv =====
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// Depends on fcp_pkg.
module fcp_div_cell import fcp_pkg::*; #(
	parameter int DW = DEN_W,
	parameter int QW = DIV1_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] dq_in,
	input  logic [DW-1:0] divisor,
	input  ctx_t          ctx_in,
	output logic          valid_out,
	output logic [DW-1:0] rem_out,
	output logic [QW-1:0] dq_out,
	output ctx_t          ctx_out
);
	logic [DW:0]   t, diff;
	logic          ge;
	logic          valid_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] dq_q;
	ctx_t          ctx_q;

	assign t    = {rem_in, dq_in[QW-1]};
	assign ge   = t >= {1'b0, divisor};
	assign diff = t - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : t[DW-1:0];
			dq_q  <= {dq_in[QW-2:0], ge};
			ctx_q <= ctx_in;
		end
	end

	assign valid_out = valid_q;
	assign rem_out   = rem_q;
	assign dq_out    = dq_q;
	assign ctx_out   = ctx_q;
endmodule

// ===== rtl/core/friction_cone_projection.sv =====
// Throughput: one contact per cycle; the whole pipeline advances together and only
// halts while a finished result is held under stall.
// Most of the depth comes from the chains of cells: 32 root steps, 38 and 30 division steps.
// Reset (arst_n low, asynchronous) clears every valid flag; payload is not reset.
module friction_cone_projection import fcp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);
`include "friction_cone_projection_macros.svh"

	// The pipeline moves as one; it holds only while a result waits under stall.
	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// Stage 1: register the contact, form the shifted normal and the magnitudes.
	logic signed [32:0] fn_w;
	logic [32:0]        afn_w;
	logic [31:0]        au_w, av_w;
	logic               v_s1;
	ctx_t               c_s1;
	logic [31:0]        au_s1, av_s1;
	logic [32:0]        afn_s1;

	assign fn_w  = {item.normal_force[31], item.normal_force}
		+ {item.cohesion_force[31], item.cohesion_force};
	assign afn_w = fn_w[32] ? ~$unsigned(fn_w) + 33'd1 : $unsigned(fn_w);
	assign au_w  = item.tangent_u[31] ? ~$unsigned(item.tangent_u) + 32'd1
		: $unsigned(item.tangent_u);
	assign av_w  = item.tangent_v[31] ? ~$unsigned(item.tangent_v) + 32'd1
		: $unsigned(item.tangent_v);

	// Stages 2 to 6: squares, cross products with mu squared, cone tests.
	logic          v_s2, v_s3, v_s4, v_s5, v_s6;
	ctx_t          c_s2, c_s3, c_s4, c_s5, c_s6;
	logic [63:0]   uu_s2, vv_s2;
	logic [31:0]   m2_s2, m2_s3;
	logic [64:0]   a2_s2, a2_s3, a2_s4, a2_s5;
	logic [63:0]   ft2_s3, ft2_s4, ft2_s5, ft2_s6;
	logic [63:0]   p0_s4, p1_s4, q0_s4;
	logic [64:0]   q1_s4;
	logic [95:0]   ftm_s5;
	logic [96:0]   fnm_s5;
	logic          less_a, less_b;
	logic          fn_zero, fn_neg;
	logic [2:0]    code_w;

	// Polar cone test compares ft^2*mu^2 against fn^2 (Q4.12 mu, hence the shift);
	// the upper cone test compares ft^2 against fn^2*mu^2.
	assign less_a  = ftm_s5 < {7'd0, a2_s5, 24'd0};
	assign less_b  = {9'd0, ft2_s5, 24'd0} < fnm_s5;
	assign fn_zero = c_s5.fn == 33'sd0;
	assign fn_neg  = c_s5.fn[32];

	always_comb begin
		priority if (!c_s5.tp) begin
			code_w = CODE_NONE;
		end else if (c_s5.m == 16'd0) begin
			code_w = CODE_FRICTIONLESS;
		end else if (fn_zero || (fn_neg && less_a)) begin
			code_w = CODE_ZERO;
		end else if (!fn_neg && less_b) begin
			code_w = CODE_INSIDE;
		end else begin
			code_w = CODE_PROJ;
		end
	end

	// Contexts entering stages 1, 3 and 6, each formed whole before its register.
	ctx_t c_s1_d, c_s3_d, c_s6_d;

	always_comb begin
		c_s1_d     = '0;
		c_s1_d.nf  = item.normal_force;
		c_s1_d.u   = item.tangent_u;
		c_s1_d.v   = item.tangent_v;
		c_s1_d.coh = item.cohesion_force;
		c_s1_d.fn  = fn_w;
		c_s1_d.m   = item.friction_coef;
		c_s1_d.tp  = item.tangents_present;
	end

	always_comb begin
		c_s3_d     = c_s2;
		c_s3_d.den = {1'b0, m2_s2} + 33'h1000000;
	end

	always_comb begin
		c_s6_d      = c_s5;
		c_s6_d.code = code_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= c_s1_d;
			au_s1  <= au_w;
			av_s1  <= av_w;
			afn_s1 <= afn_w;

			c_s2  <= c_s1;
			uu_s2 <= {32'd0, au_s1} * {32'd0, au_s1};
			vv_s2 <= {32'd0, av_s1} * {32'd0, av_s1};
			m2_s2 <= {16'd0, c_s1.m} * {16'd0, c_s1.m};
			a2_s2 <= {32'd0, afn_s1} * {32'd0, afn_s1};

			c_s3   <= c_s3_d;
			ft2_s3 <= uu_s2 + vv_s2;
			m2_s3  <= m2_s2;
			a2_s3  <= a2_s2;

			// Wide products split into 32-bit partial products.
			c_s4   <= c_s3;
			p0_s4  <= {32'd0, ft2_s3[31:0]} * {32'd0, m2_s3};
			p1_s4  <= {32'd0, ft2_s3[63:32]} * {32'd0, m2_s3};
			q0_s4  <= {32'd0, a2_s3[31:0]} * {32'd0, m2_s3};
			q1_s4  <= {32'd0, a2_s3[64:32]} * {33'd0, m2_s3};
			ft2_s4 <= ft2_s3;
			a2_s4  <= a2_s3;

			c_s5   <= c_s4;
			ftm_s5 <= {p1_s4, 32'd0} + {32'd0, p0_s4};
			fnm_s5 <= {q1_s4, 32'd0} + {33'd0, q0_s4};
			ft2_s5 <= ft2_s4;
			a2_s5  <= a2_s4;

			c_s6   <= c_s6_d;
			ft2_s6 <= ft2_s5;
		end
	end

	// Square root chain: one result bit per cell.
	logic        sq_valid [0:SQ_STEPS];
	logic [63:0] sq_x     [0:SQ_STEPS];
	logic [63:0] sq_res   [0:SQ_STEPS];
	ctx_t        sq_ctx   [0:SQ_STEPS];

	assign sq_valid[0] = v_s6;
	assign sq_x[0]     = ft2_s6;
	assign sq_res[0]   = 64'd0;
	assign sq_ctx[0]   = c_s6;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		fcp_sqrt_cell #(.STEP(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (sq_valid[k]),
			.x_in      (sq_x[k]),
			.res_in    (sq_res[k]),
			.ctx_in    (sq_ctx[k]),
			.valid_out (sq_valid[k+1]),
			.x_out     (sq_x[k+1]),
			.res_out   (sq_res[k+1]),
			.ctx_out   (sq_ctx[k+1])
		);
	end

	// Projection numerator and the rounded dividend for the first division.
	logic               v_d0, v_d1;
	ctx_t               c_d0, c_d1;
	logic [47:0]        ftm_d0;
	logic signed [49:0] num_w;
	logic [48:0]        anum_w;
	logic [61:0]        dividend_w;
	logic [DEN_W-1:0]   rem_d1;
	logic [DIV1_BITS-1:0] dq_d1;

	assign num_w      = $signed({2'b00, ftm_d0})
		+ $signed({{5{c_d0.fn[32]}}, c_d0.fn, 12'd0});
	assign anum_w     = num_w[49] ? ~$unsigned(num_w[48:0]) + 49'd1 : $unsigned(num_w[48:0]);
	assign dividend_w = {1'b0, anum_w, 12'd0} + {30'd0, c_d0.den[DEN_W-1:1]};

	ctx_t c_d0_d, c_d1_d;

	always_comb begin
		c_d0_d    = sq_ctx[SQ_STEPS];
		c_d0_d.ft = sq_res[SQ_STEPS][31:0];
	end

	always_comb begin
		c_d1_d     = c_d0;
		c_d1_d.neg = num_w[49];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d0 <= 1'b0;
			v_d1 <= 1'b0;
		end else if (en) begin
			v_d0 <= sq_valid[SQ_STEPS];
			v_d1 <= v_d0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_d0   <= c_d0_d;
			ftm_d0 <= {16'd0, sq_res[SQ_STEPS][31:0]} * {32'd0, sq_ctx[SQ_STEPS].m};

			// The quotient fits 38 bits, so the top dividend bits seed the remainder.
			c_d1   <= c_d1_d;
			rem_d1 <= {{(DEN_W-24){1'b0}}, dividend_w[61:DIV1_BITS]};
			dq_d1  <= dividend_w[DIV1_BITS-1:0];
		end
	end

	logic                 d1_valid [0:DIV1_BITS];
	logic [DEN_W-1:0]     d1_rem   [0:DIV1_BITS];
	logic [DIV1_BITS-1:0] d1_dq    [0:DIV1_BITS];
	ctx_t                 d1_ctx   [0:DIV1_BITS];

	assign d1_valid[0] = v_d1;
	assign d1_rem[0]   = rem_d1;
	assign d1_dq[0]    = dq_d1;
	assign d1_ctx[0]   = c_d1;

	for (genvar k = 0; k < DIV1_BITS; k++) begin : g_div1
		fcp_div_cell #(.DW(DEN_W), .QW(DIV1_BITS)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (d1_valid[k]),
			.rem_in    (d1_rem[k]),
			.dq_in     (d1_dq[k]),
			.divisor   (d1_ctx[k].den),
			.ctx_in    (d1_ctx[k]),
			.valid_out (d1_valid[k+1]),
			.rem_out   (d1_rem[k+1]),
			.dq_out    (d1_dq[k+1]),
			.ctx_out   (d1_ctx[k+1])
		);
	end

	// Scale ratio setup: a = p*mu against b = ft*4096, clamped cases flagged.
	logic               v_r0, v_r1;
	ctx_t               c_r0, c_r1;
	logic [53:0]        a_r0;
	logic [RATIO_W-1:0] rem_r1;
	ctx_t               c_r0_d, c_r1_d;

	always_comb begin
		c_r0_d    = d1_ctx[DIV1_BITS];
		c_r0_d.pm = d1_dq[DIV1_BITS];
		c_r0_d.b  = {d1_ctx[DIV1_BITS].ft, 12'd0};
	end

	always_comb begin
		c_r1_d        = c_r0;
		c_r1_d.r_zero = c_r0.neg || (c_r0.pm == '0) || (c_r0.ft == 32'd0);
		c_r1_d.r_full = a_r0 >= {10'd0, c_r0.b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r0 <= 1'b0;
			v_r1 <= 1'b0;
		end else if (en) begin
			v_r0 <= d1_valid[DIV1_BITS];
			v_r1 <= v_r0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_r0   <= c_r0_d;
			a_r0   <= {16'd0, d1_dq[DIV1_BITS]} * {38'd0, d1_ctx[DIV1_BITS].m};

			c_r1   <= c_r1_d;
			rem_r1 <= a_r0[RATIO_W-1:0];
		end
	end

	logic                 d2_valid [0:DIV2_BITS];
	logic [RATIO_W-1:0]   d2_rem   [0:DIV2_BITS];
	logic [DIV2_BITS-1:0] d2_dq    [0:DIV2_BITS];
	ctx_t                 d2_ctx   [0:DIV2_BITS];

	assign d2_valid[0] = v_r1;
	assign d2_rem[0]   = rem_r1;
	assign d2_dq[0]    = '0;
	assign d2_ctx[0]   = c_r1;

	for (genvar k = 0; k < DIV2_BITS; k++) begin : g_div2
		fcp_div_cell #(.DW(RATIO_W), .QW(DIV2_BITS)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (d2_valid[k]),
			.rem_in    (d2_rem[k]),
			.dq_in     (d2_dq[k]),
			.divisor   (d2_ctx[k].b),
			.ctx_in    (d2_ctx[k]),
			.valid_out (d2_valid[k+1]),
			.rem_out   (d2_rem[k+1]),
			.dq_out    (d2_dq[k+1]),
			.ctx_out   (d2_ctx[k+1])
		);
	end

	// Tangent scaling by the Q1.30 ratio, then rounding and output selection.
	ctx_t        c_end;
	logic [30:0] r_w;
	logic [31:0] au_e, av_e;
	logic        v_m0;
	ctx_t        c_m0;
	logic [62:0] pu_m0, pv_m0;

	assign c_end = d2_ctx[DIV2_BITS];
	assign au_e  = c_end.u[31] ? ~$unsigned(c_end.u) + 32'd1 : $unsigned(c_end.u);
	assign av_e  = c_end.v[31] ? ~$unsigned(c_end.v) + 32'd1 : $unsigned(c_end.v);

	always_comb begin
		priority if (c_end.r_zero) begin
			r_w = 31'd0;
		end else if (c_end.r_full) begin
			r_w = 31'h40000000;
		end else begin
			r_w = {1'b0, d2_dq[DIV2_BITS]};
		end
	end

	logic [62:0]        ru_w, rv_w;
	logic [32:0]        qu_w, qv_w;
	logic signed [39:0] su_w, sv_w, ps_w, on_w;
	result_t            res_w;
	result_t            result_q;
	logic               result_valid_q;

	assign ru_w = pu_m0 + 63'h20000000;
	assign rv_w = pv_m0 + 63'h20000000;
	assign qu_w = ru_w[62:30];
	assign qv_w = rv_w[62:30];
	assign su_w = c_m0.u[31] ? -$signed({7'd0, qu_w}) : $signed({7'd0, qu_w});
	assign sv_w = c_m0.v[31] ? -$signed({7'd0, qv_w}) : $signed({7'd0, qv_w});
	assign ps_w = c_m0.neg ? -$signed({2'd0, c_m0.pm}) : $signed({2'd0, c_m0.pm});
	assign on_w = ps_w - $signed({{8{c_m0.coh[31]}}, c_m0.coh});

	always_comb begin
		res_w.case_code = c_m0.code;
		unique case (c_m0.code)
			CODE_NONE, CODE_INSIDE: begin
				res_w.new_normal = c_m0.nf;
				res_w.new_u      = c_m0.u;
				res_w.new_v      = c_m0.v;
			end
			CODE_FRICTIONLESS: begin
				res_w.new_normal = c_m0.fn[32] ? 32'sd0 : c_m0.nf;
				res_w.new_u      = 32'sd0;
				res_w.new_v      = 32'sd0;
			end
			CODE_PROJ: begin
				res_w.new_normal = sat32(on_w);
				res_w.new_u      = sat32(su_w);
				res_w.new_v      = sat32(sv_w);
			end
			default: begin
				res_w.new_normal = 32'sd0;
				res_w.new_u      = 32'sd0;
				res_w.new_v      = 32'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m0           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			v_m0           <= d2_valid[DIV2_BITS];
			result_valid_q <= v_m0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_m0     <= c_end;
			pu_m0    <= {31'd0, au_e} * {32'd0, r_w};
			pv_m0    <= {31'd0, av_e} * {32'd0, r_w};
			result_q <= res_w;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`FCP_ASSERT_IMP(a_zero_case, result_valid && result.case_code == CODE_ZERO, result.new_normal == 32'sd0 && result.new_u == 32'sd0 && result.new_v == 32'sd0, "zeroed case with nonzero output")
	`FCP_ASSERT_IMP(a_frictionless, result_valid && result.case_code == CODE_FRICTIONLESS, result.new_u == 32'sd0 && result.new_v == 32'sd0, "frictionless case with tangents")
	`FCP_ASSERT_NXT(a_front_hold, item_stall, $stable(v_s1), "front stage moved while halted")
endmodule

// ===== dv/friction_cone_projection_test.sv =====
// Self-checking testbench for the friction cone projection pipeline.
// Depends on fcp_pkg and friction_cone_projection; predicts each result in place.
`timescale 1ns / 100ps

module friction_cone_projection_test;
	import fcp_pkg::*;

	localparam int LATENCY     = 112;
	localparam int STALL_LIMIT = 5000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Results predicted for accepted contacts, oldest first.
	result_t projected_q[$];
	int      mismatches;
	int      idle_cycles;

	// Sender shaping: bursts of up to burst_max transfers separated by idle gaps no
	// longer than gap_max. A gap_max of zero keeps valid high throughout.
	int burst_left;
	int burst_max;
	int gap_max;
	// Receiver shaping: percentage of cycles stalled, and occasional long stalls.
	int stall_pct;
	int long_stall_len;

	friction_cone_projection i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic longint unsigned magnitude(input longint x);
		return (x < 0) ? longint'(-x) : longint'(x);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Scales a tangent by a Q1.30 ratio, rounding half away from zero.
	function automatic longint scale_tangent(input longint t, input longint unsigned ratio);
		longint unsigned q;
		q = (magnitude(t) * ratio + (64'd1 << 29)) >> 30;
		return (t < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] clip32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic result_t project_contact(input item_t c);
		longint nf, u, v, coh, fn, num, p, on, ou, ov;
		longint unsigned mu, afn, ft2, mu2, ft, den, pm, a, b, ratio;
		logic [127:0] ft2_mu2, fn2_shift, fnmu_sq, ft2_shift, quot;
		logic [2:0] code;
		result_t res;
		nf  = 64'(c.normal_force);
		u   = 64'(c.tangent_u);
		v   = 64'(c.tangent_v);
		coh = 64'(c.cohesion_force);
		mu  = 64'(c.friction_coef);
		fn  = nf + coh;
		on  = nf;
		ou  = u;
		ov  = v;
		if (!c.tangents_present) begin
			code = CODE_NONE;
		end else if (mu == 0) begin
			ou = 0;
			ov = 0;
			if (fn < 0) on = 0;
			code = CODE_FRICTIONLESS;
		end else begin
			afn       = magnitude(fn);
			ft2       = magnitude(u) * magnitude(u) + magnitude(v) * magnitude(v);
			mu2       = mu * mu;
			ft2_mu2   = 128'(ft2) * 128'(mu2);
			fn2_shift = (128'(afn) * 128'(afn)) << 24;
			fnmu_sq   = 128'(afn * mu) * 128'(afn * mu);
			ft2_shift = 128'(ft2) << 24;
			if (fn == 0 || (fn <= 0 && ft2_mu2 < fn2_shift)) begin
				on   = 0;
				ou   = 0;
				ov   = 0;
				code = CODE_ZERO;
			end else if (fn > 0 && ft2_shift < fnmu_sq) begin
				code = CODE_INSIDE;
			end else begin
				ft    = floor_sqrt(ft2);
				num   = longint'(ft * mu) + fn * 4096;
				den   = mu2 + (64'd1 << 24);
				pm    = (magnitude(num) * 4096 + (den >> 1)) / den;
				p     = (num < 0) ? -longint'(pm) : longint'(pm);
				ratio = 0;
				if (p > 0 && ft != 0) begin
					a = longint'(p) * mu;
					b = ft * 4096;
					if (a >= b) begin
						ratio = 64'd1 << 30;
					end else begin
						quot  = (128'(a) << 30) / 128'(b);
						ratio = quot[63:0];
					end
				end
				ou   = scale_tangent(u, ratio);
				ov   = scale_tangent(v, ratio);
				on   = p - coh;
				code = CODE_PROJ;
			end
		end
		res.new_normal = clip32(on);
		res.new_u      = clip32(ou);
		res.new_v      = clip32(ov);
		res.case_code  = code;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Receiver and checking. Outputs are sampled on the falling edge, where
	// they are settled; the transfer itself happens at the next rising edge.
	// ------------------------------------------------------------------

	int long_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			long_left    <= 0;
		end else if (long_left > 0) begin
			result_stall <= 1'b1;
			long_left    <= long_left - 1;
		end else if (long_stall_len > 0 && $urandom_range(99) == 0) begin
			result_stall <= 1'b1;
			long_left    <= long_stall_len;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(negedge clk) begin
		result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (projected_q.size() == 0) begin
				$error("result transfer with no contact outstanding");
				mismatches++;
			end else begin
				exp_res = projected_q.pop_front();
				if (result.new_normal !== exp_res.new_normal) begin
					$error("new_normal expected %0d got %0d", exp_res.new_normal,
						result.new_normal);
					mismatches++;
				end
				if (result.new_u !== exp_res.new_u) begin
					$error("new_u expected %0d got %0d", exp_res.new_u, result.new_u);
					mismatches++;
				end
				if (result.new_v !== exp_res.new_v) begin
					$error("new_v expected %0d got %0d", exp_res.new_v, result.new_v);
					mismatches++;
				end
				if (result.case_code !== exp_res.case_code) begin
					$error("case_code expected %0d got %0d", exp_res.case_code,
						result.case_code);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: cycles in which neither channel completes a transfer.
	always @(negedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Presents one contact and returns once it has been transferred. The
	// prediction is queued at the edge of the transfer.
	task automatic send_contact(input item_t c);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? $urandom_range(gap_max) : 0;
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(burst_max, 1);
		end
		item       <= c;
		item_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end while (!taken);
		projected_q.push_back(project_contact(c));
		burst_left--;
	endtask

	task automatic stop_sending();
		item_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_drained();
		while (projected_q.size() != 0) @(posedge clk);
	endtask

	function automatic item_t make_contact(input logic signed [31:0] nf,
			input logic signed [31:0] u, input logic signed [31:0] v,
			input logic [15:0] mu, input logic signed [31:0] coh, input logic tp);
		item_t c;
		c.normal_force     = nf;
		c.tangent_u        = u;
		c.tangent_v        = v;
		c.friction_coef    = mu;
		c.cohesion_force   = coh;
		c.tangents_present = tp;
		return c;
	endfunction

	// A Q16.16 value drawn from several magnitude classes, so that the cone
	// tests see comparable normal and tangential forces as well as extremes.
	function automatic logic signed [31:0] pick_force();
		case ($urandom_range(6))
			0: return $urandom;
			1: return 32'sh80000000;
			2: return 32'sh7fffffff;
			3: return 0;
			4: return $signed($urandom_range(32'h0001ffff)) - 32'sh00010000;
			5: return $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
			default: return $signed($urandom_range(32'h00ffffff));
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(16'h1000));
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		burst_max = 4; gap_max = 3; stall_pct = 20; long_stall_len = 0;
		// No tangents: passes through, extremes included.
		send_contact(make_contact(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'hffff,
			32'sh7fffffff, 1'b0));
		send_contact(make_contact(32'sh7fffffff, 0, -1, 0, 32'sh80000000, 1'b0));
		// Frictionless, with the shifted normal negative and then non-negative.
		send_contact(make_contact(32'sh00010000, 32'sh00050000, -32'sh00030000, 0,
			-32'sh00020000, 1'b1));
		send_contact(make_contact(32'sh00010000, 32'sh00050000, 32'sh00030000, 0,
			32'sh00000000, 1'b1));
		// Shifted normal exactly zero: origin case.
		send_contact(make_contact(32'sh00010000, 32'sh00100000, 0, 16'h1000,
			-32'sh00010000, 1'b1));
		// Negative normal inside the lower cone.
		send_contact(make_contact(-32'sh00100000, 32'sh00001000, 0, 16'h1000, 0, 1'b1));
		// Negative normal outside the lower cone: projection.
		send_contact(make_contact(-32'sh00001000, 32'sh00100000, 32'sh00100000, 16'h1000,
			0, 1'b1));
		// Inside the upper cone.
		send_contact(make_contact(32'sh00100000, 32'sh00001000, -32'sh00001000, 16'h0800,
			32'sh00000100, 1'b1));
		// An ordinary projection, then one contact inside the upper cone and one zeroed.
		send_contact(make_contact(32'sh00010000, 32'sh00100000, -32'sh00080000, 16'h0800,
			0, 1'b1));
		send_contact(make_contact(32'sh00100000, 32'sh00010000, 0, 16'hffff, 0, 1'b1));
		send_contact(make_contact(32'sh00010000, 0, 0, 16'h1000, -32'sh00010001, 1'b1));
		// Boundary of the upper cone: tangent equal to mu times normal.
		send_contact(make_contact(32'sh00010000, 32'sh00010000, 0, 16'h1000, 0, 1'b1));
		// Full-scale and smallest operands, pushing the saturation of the normal.
		send_contact(make_contact(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'hffff,
			32'sh80000000, 1'b1));
		send_contact(make_contact(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'hffff,
			32'sh7fffffff, 1'b1));
		send_contact(make_contact(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'h0001,
			32'sh80000000, 1'b1));
		send_contact(make_contact(-1, 1, -1, 16'h0001, 0, 1'b1));
		send_contact(make_contact(32'sh80000000, 32'sh00000001, 0, 16'hffff,
			32'sh7fffffff, 1'b1));
		stop_sending();
	endtask

	// The sender pauses until every outstanding contact has left the pipeline.
	task automatic test_drain_pause();
		@(posedge clk);
		burst_max = 8; gap_max = 0; stall_pct = 50; long_stall_len = 30;
		repeat (40) send_contact(make_contact(pick_force(), pick_force(), pick_force(),
			pick_coef(), pick_force(), 1'b1));
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random_stream();
		item_t c;
		for (int i = 0; i < 460; i++) begin
			// Change the shape of idling every hundred transfers; the first and the last
			// stretch run back to back on both sides.
			if (i % 100 == 0) begin
				case ((i / 100) % 4)
					0: begin burst_max = 1000; gap_max = 0; stall_pct = 0;  long_stall_len = 0;  end
					1: begin burst_max = 3;    gap_max = 4; stall_pct = 30; long_stall_len = 0;  end
					2: begin burst_max = 20;   gap_max = 8; stall_pct = 10; long_stall_len = 20; end
					default: begin burst_max = 6; gap_max = 2; stall_pct = 70; long_stall_len = 0; end
				endcase
			end
			c = make_contact(pick_force(), pick_force(), pick_force(), pick_coef(),
				pick_force(), ($urandom_range(9) != 0));
			// Keep cohesion small most of the time so that the shifted normal
			// is governed by the normal force and all cone cases occur.
			if ($urandom_range(2) != 0) c.cohesion_force = $signed($urandom_range(511)) - 256;
			send_contact(c);
		end
		stop_sending();
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		mismatches     = 0;
		burst_left     = 0;
		burst_max      = 1;
		gap_max        = 0;
		stall_pct      = 0;
		long_stall_len = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_drain_pause();
		test_random_stream();

		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && projected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== friction_cone_projection.f =====
+incdir+rtl/core
rtl/core/fcp_pkg.sv
rtl/core/fcp_sqrt_cell.sv
rtl/core/fcp_div_cell.sv
rtl/core/friction_cone_projection.sv
dv/friction_cone_projection_test.sv
